// ===== hdl/mfs_pkg.sv =====
// Shared constants and word types of the multilevel feedback scheduler.
// Used by the channel interfaces, the scheduling core, the output buffer and the top level.
package mfs_pkg;

    localparam int SLOTS      = 8;
    localparam int LEVELS     = 3;
    localparam int TIME_BITS  = 16;
    localparam int BURST_BITS = 8;

    localparam int SLOT_W  = 3;
    localparam int LEVEL_W = 2;
    localparam int PTR_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int QUANT_W = $clog2((1 << (LEVELS - 1)) + 1);

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [SLOT_W-1:0]     slot;
        logic [BURST_BITS-1:0] burst;
    } t_item;

    typedef struct packed {
        logic                 idle;
        logic [SLOT_W-1:0]    run_slot;
        logic [LEVEL_W-1:0]   run_level;
        logic                 finished;
        logic [TIME_BITS-1:0] turnaround;
        logic [TIME_BITS-1:0] waiting;
    } t_result;

endpackage

// ===== hdl/mfs_if.sv =====
// Valid/ready channel interfaces for input items and result words.
// Depends on mfs_pkg for the payload types.
interface mfs_item_if;
    logic          valid;
    logic          ready;
    mfs_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mfs_result_if;
    logic             valid;
    logic             ready;
    mfs_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/multilevel_feedback_scheduler.sv =====
// Multilevel feedback scheduler top level: input register, scheduling core, result buffer.
// Depends on mfs_pkg, mfs_if, mfs_core and mfs_out_buf.
//
// Usage:
//   i_item carries arrival words (func = 0, slot, burst) and tick words (func = 1).
//   o_result carries one word per tick: the slot and level that ran, or idle, and the
//   turnaround and waiting time when that process finished. Arrivals give no word.
//   A word is moved when valid and ready are both high at a rising edge of i_clk.
// Timing:
//   An accepted word is held in an input register until the core takes it; the core
//   updates the slot table and level FIFOs in a single pass and writes the result
//   into a two-word buffer, from which it is offered on o_result. One word is taken
//   every cycle while the receiver keeps up and the result buffer has space.
// Stall:
//   When the result buffer is full a pending tick waits in the input register and
//   i_item.ready drops; arrivals still pass as long as the register is not blocked.
// Reset:
//   i_rst_n low at a clock edge clears time, slot activity, queues and the running
//   process; no words are in flight afterwards.
module multilevel_feedback_scheduler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mfs_item_if.sink     i_item,
    mfs_result_if.source o_result
);

    logic             r_in_valid;
    mfs_pkg::t_item   r_in;
    logic             buf_space;
    logic             fire;
    logic             push;
    mfs_pkg::t_result res;

    assign fire = r_in_valid && ((r_in.func == mfs_pkg::FUNC_ARRIVAL) || buf_space);
    assign push = fire && (r_in.func == mfs_pkg::FUNC_TICK);
    assign i_item.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    // hold the word until the core takes it
    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in <= i_item.data;
        end
    end

    mfs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (res)
    );

    mfs_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (res),
        .o_space  (buf_space),
        .o_result (o_result)
    );

endmodule

// ===== hdl/mfs_core.sv =====
// Scheduling core: slot table, one register FIFO per level, running process and time.
// Processes one registered input word per fire; depends on mfs_pkg.
module mfs_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  mfs_pkg::t_item   i_item,
    output mfs_pkg::t_result o_res
);

    localparam int SLOTS   = mfs_pkg::SLOTS;
    localparam int LEVELS  = mfs_pkg::LEVELS;
    localparam int TB      = mfs_pkg::TIME_BITS;
    localparam int BB      = mfs_pkg::BURST_BITS;
    localparam int SLOT_W  = mfs_pkg::SLOT_W;
    localparam int LEVEL_W = mfs_pkg::LEVEL_W;
    localparam int PTR_W   = mfs_pkg::PTR_W;
    localparam int CNT_W   = mfs_pkg::CNT_W;
    localparam int QUANT_W = mfs_pkg::QUANT_W;

    // slot table
    logic [TB-1:0]       r_arrival   [SLOTS];
    logic [BB-1:0]       r_burst     [SLOTS];
    logic [BB-1:0]       r_remaining [SLOTS];
    logic [SLOTS-1:0]    r_active;

    // level FIFOs
    logic [SLOT_W-1:0]   r_q    [LEVELS][SLOTS];
    logic [PTR_W-1:0]    r_head [LEVELS];
    logic [CNT_W-1:0]    r_cnt  [LEVELS];

    logic [TB-1:0]       r_time;
    logic                r_run_valid;
    logic [SLOT_W-1:0]   r_run_slot;
    logic [LEVEL_W-1:0]  r_run_level;
    logic [QUANT_W-1:0]  r_quant;

    logic                is_tick;
    logic                arrive_ok;
    logic [QUANT_W-1:0]  q_lim;
    logic                demote;
    logic [LEVEL_W-1:0]  dem_level;
    logic                push;
    logic [LEVEL_W-1:0]  push_level;
    logic [SLOT_W-1:0]   push_slot;
    logic                keep;
    logic                pop_any;
    logic                pop;
    logic [LEVEL_W-1:0]  pop_level;
    logic                pop_empty;
    logic [SLOT_W-1:0]   pop_head;
    logic [SLOT_W-1:0]   pop_slot;
    logic [LEVELS-1:0]   push_here;
    logic [LEVELS-1:0]   pop_here;
    logic [PTR_W-1:0]    tail [LEVELS];
    logic                run_now;
    logic [SLOT_W-1:0]   cur_slot;
    logic [PTR_W-1:0]    cur_idx;
    logic [LEVEL_W-1:0]  cur_level;
    logic [QUANT_W-1:0]  q_base;
    logic [BB-1:0]       rem;
    logic [BB-1:0]       rem_new;
    logic                done;
    logic [TB-1:0]       time_new;
    logic [TB-1:0]       tat;
    logic [TB-1:0]       wt;
    logic [PTR_W-1:0]    in_idx;

    assign is_tick   = (i_item.func == mfs_pkg::FUNC_TICK);
    assign in_idx    = i_item.slot[PTR_W-1:0];
    assign arrive_ok = !is_tick && (32'(i_item.slot) < 32'(SLOTS)) &&
                       (i_item.burst != '0) && !r_active[in_idx];

    assign q_lim     = QUANT_W'(1) << r_run_level;
    assign demote    = is_tick && r_run_valid && (r_quant >= q_lim);
    assign dem_level = (r_run_level == LEVEL_W'(LEVELS - 1)) ? r_run_level
                                                             : r_run_level + LEVEL_W'(1);
    assign push       = arrive_ok || demote;
    assign push_level = demote ? dem_level : '0;
    assign push_slot  = demote ? r_run_slot : i_item.slot;
    assign keep       = r_run_valid && !demote;

    // lowest level that is non-empty once this tick's requeue is counted
    always_comb begin
        pop_any   = 1'b0;
        pop_level = '0;
        pop_empty = 1'b0;
        pop_head  = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_cnt[l] != '0 || (push && push_level == LEVEL_W'(l))) begin
                pop_any   = 1'b1;
                pop_level = LEVEL_W'(l);
                pop_empty = (r_cnt[l] == '0);
                pop_head  = r_q[l][r_head[l]];
            end
        end
    end

    assign pop      = is_tick && !keep && pop_any;
    // an empty level hands the requeued slot straight through
    assign pop_slot = pop_empty ? push_slot : pop_head;

    always_comb begin
        logic [PTR_W:0] sum;
        for (int l = 0; l < LEVELS; l++) begin
            push_here[l] = push && (push_level == LEVEL_W'(l)) && (r_cnt[l] < CNT_W'(SLOTS));
            pop_here[l]  = pop && (pop_level == LEVEL_W'(l));
            sum = (PTR_W + 1)'(r_head[l]) + (PTR_W + 1)'(r_cnt[l]);
            if (sum >= (PTR_W + 1)'(SLOTS)) begin
                sum = sum - (PTR_W + 1)'(SLOTS);
            end
            tail[l] = sum[PTR_W-1:0];
        end
    end

    assign run_now   = is_tick && (keep || pop);
    assign cur_slot  = keep ? r_run_slot : pop_slot;
    assign cur_idx   = cur_slot[PTR_W-1:0];
    assign cur_level = keep ? r_run_level : pop_level;
    assign q_base    = keep ? r_quant : '0;
    assign rem       = r_remaining[cur_idx];
    assign rem_new   = (rem != '0) ? rem - BB'(1) : rem;
    assign done      = run_now && (rem_new == '0);
    assign time_new  = r_time + TB'(1);
    assign tat       = time_new - r_arrival[cur_idx];
    assign wt        = tat - TB'(r_burst[cur_idx]);

    always_comb begin
        o_res = '0;
        if (!run_now) begin
            o_res.idle = 1'b1;
        end else begin
            o_res.run_slot  = cur_slot;
            o_res.run_level = cur_level;
            o_res.finished  = done;
            if (done) begin
                o_res.turnaround = tat;
                o_res.waiting    = wt;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_time      <= '0;
            r_run_valid <= 1'b0;
            r_run_slot  <= '0;
            r_run_level <= '0;
            r_quant     <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_cnt[l]  <= '0;
            end
        end else if (i_fire) begin
            if (arrive_ok) begin
                r_active[in_idx] <= 1'b1;
            end
            if (is_tick) begin
                r_time      <= time_new;
                r_run_valid <= run_now && !done;
                if (pop) begin
                    r_run_slot  <= pop_slot;
                    r_run_level <= pop_level;
                end
                if (run_now) begin
                    r_quant <= done ? '0 : q_base + QUANT_W'(1);
                end
                if (done) begin
                    r_active[cur_idx] <= 1'b0;
                end
            end
            for (int l = 0; l < LEVELS; l++) begin
                if (pop_here[l]) begin
                    r_head[l] <= (r_head[l] == PTR_W'(SLOTS - 1)) ? '0 : r_head[l] + PTR_W'(1);
                end
                r_cnt[l] <= r_cnt[l] + CNT_W'(push_here[l]) - CNT_W'(pop_here[l]);
            end
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (arrive_ok) begin
                r_arrival[in_idx]   <= r_time;
                r_burst[in_idx]     <= i_item.burst;
                r_remaining[in_idx] <= i_item.burst;
            end
            if (run_now) begin
                r_remaining[cur_idx] <= rem_new;
            end
            for (int l = 0; l < LEVELS; l++) begin
                if (push_here[l]) begin
                    r_q[l][tail[l]] <= push_slot;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_run_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> r_active[r_run_slot[PTR_W-1:0]])
        else $error("running slot is not active");

    a_quant_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_quant <= q_lim))
        else $error("quantum overrun");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (32'(r_run_level) < 32'(LEVELS)))
        else $error("running level out of range");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && done) |=> !r_run_valid)
        else $error("finished process still running");
`endif

endmodule

// ===== hdl/mfs_out_buf.sv =====
// Two-word result buffer that decouples the core from a stalling receiver.
// Depends on mfs_pkg and mfs_result_if.
module mfs_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mfs_pkg::t_result i_word,
    output logic             o_space,
    mfs_result_if.source     o_result
);

    mfs_pkg::t_result r_buf [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             pop;

    assign o_space        = (r_cnt != 2'd2);
    assign o_result.valid = (r_cnt != 2'd0);
    assign o_result.data  = r_buf[r_rptr];
    assign pop            = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_word;
        end
    end

endmodule

// ===== bench/tb_multilevel_feedback_scheduler.sv =====
// Self-checking bench for multilevel_feedback_scheduler: random arrivals and ticks
// against an in-bench scheduler predictor, with random idles on both channels.
// Depends on mfs_pkg, mfs_if and the scheduler RTL.
module tb_multilevel_feedback_scheduler;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 6;
    localparam int RUN_LIMIT = 600000;
    localparam int RANDOM_WORDS = 750;
    localparam int HOLD_CYCLES = 80;

    localparam int SLOTS      = mfs_pkg::SLOTS;
    localparam int LEVELS     = mfs_pkg::LEVELS;
    localparam int TIME_BITS  = mfs_pkg::TIME_BITS;
    localparam int BURST_BITS = mfs_pkg::BURST_BITS;
    localparam int SLOT_W     = mfs_pkg::SLOT_W;
    localparam int LEVEL_W    = mfs_pkg::LEVEL_W;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mfs_item_if   item_ch ();
    mfs_result_if res_ch ();

    multilevel_feedback_scheduler dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Scheduler state as predicted from accepted words.
    logic [TIME_BITS-1:0]  now_t = '0;
    logic [TIME_BITS-1:0]  arr_t [SLOTS];
    logic [BURST_BITS-1:0] burst_of [SLOTS];
    logic [BURST_BITS-1:0] left_of [SLOTS];
    logic [LEVEL_W-1:0]    lvl_of [SLOTS];
    logic [SLOTS-1:0]      live = '0;
    logic [SLOT_W-1:0]     level_fifo [LEVELS][$];
    logic [SLOT_W-1:0]     cur_slot = '0;
    logic                  cur_valid = 1'b0;
    int unsigned           used = 0;

    mfs_pkg::t_item   item_backlog [$];
    mfs_pkg::t_result expected_runs [$];
    int unsigned mismatch_count = 0;
    int unsigned runs_checked = 0;
    int unsigned words_in = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          hold_wanted = 1'b0;
    bit          quiet;

    assign quiet = (words_in >= 300) && (words_in < 450);

    task automatic flag_mismatch(input string msg);
        $display("mismatch at result %0d: %s", runs_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    // One scheduler step; a tick queues the run it should report.
    task automatic advance_scheduler(input mfs_pkg::t_item w);
        mfs_pkg::t_result     r;
        logic [SLOT_W-1:0]    s;
        logic [TIME_BITS-1:0] tat;
        if (w.func == mfs_pkg::FUNC_ARRIVAL) begin
            if (w.burst != 0 && !live[w.slot]) begin
                arr_t[w.slot]    = now_t;
                burst_of[w.slot] = w.burst;
                left_of[w.slot]  = w.burst;
                lvl_of[w.slot]   = '0;
                live[w.slot]     = 1'b1;
                level_fifo[0].push_back(w.slot);
            end
            return;
        end
        // demote a process that used its whole quantum, saturate at the last level
        if (cur_valid && used >= (1 << lvl_of[cur_slot])) begin
            if (lvl_of[cur_slot] < LEVELS - 1)
                lvl_of[cur_slot] = lvl_of[cur_slot] + 1'b1;
            level_fifo[lvl_of[cur_slot]].push_back(cur_slot);
            cur_valid = 1'b0;
        end
        if (!cur_valid) begin
            for (int l = 0; l < LEVELS; l++) begin
                if (level_fifo[l].size() != 0) begin
                    cur_slot  = level_fifo[l].pop_front();
                    cur_valid = 1'b1;
                    used      = 0;
                    break;
                end
            end
        end
        now_t = now_t + 1'b1;
        r = '0;
        if (!cur_valid) begin
            r.idle = 1'b1;
        end else begin
            s = cur_slot;
            r.run_slot  = s;
            r.run_level = lvl_of[s];
            if (left_of[s] != 0)
                left_of[s] = left_of[s] - 1'b1;
            used++;
            if (left_of[s] == 0) begin
                tat          = now_t - arr_t[s];
                r.finished   = 1'b1;
                r.turnaround = tat;
                r.waiting    = tat - TIME_BITS'(burst_of[s]);
                live[s]      = 1'b0;
                cur_valid    = 1'b0;
                used         = 0;
            end
        end
        expected_runs.push_back(r);
    endtask

    function automatic bit take_break();
        if (quiet)
            return 1'b0;
        return $urandom_range(99) < 9;
    endfunction

    function automatic mfs_pkg::t_item make_word(input logic f, input int s, input int b);
        mfs_pkg::t_item w;
        w.func  = f;
        w.slot  = s[SLOT_W-1:0];
        w.burst = b[BURST_BITS-1:0];
        return w;
    endfunction

    // Slots active in the predictor or claimed by an arrival not yet accepted.
    function automatic logic [SLOTS-1:0] busy_mask();
        logic [SLOTS-1:0] m;
        m = live;
        foreach (item_backlog[i])
            if (item_backlog[i].func == mfs_pkg::FUNC_ARRIVAL && item_backlog[i].burst != 0)
                m[item_backlog[i].slot] = 1'b1;
        if (item_ch.valid && item_ch.data.func == mfs_pkg::FUNC_ARRIVAL &&
            item_ch.data.burst != 0)
            m[item_ch.data.slot] = 1'b1;
        return m;
    endfunction

    function automatic int draw_burst();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return $urandom_range(6, 1);
        if (roll < 97)
            return $urandom_range(30, 7);
        return $urandom_range(255, 31);
    endfunction

    task automatic queue_word(input mfs_pkg::t_item w);
        while (item_backlog.size() >= 2)
            @(negedge i_clk);
        item_backlog.push_back(w);
    endtask

    task automatic queue_tick();
        queue_word(make_word(mfs_pkg::FUNC_TICK, $urandom_range(SLOTS - 1),
                             $urandom_range(255)));
    endtask

    task automatic queue_fresh_arrival(input int b);
        logic [SLOTS-1:0] m;
        int               s;
        m = busy_mask();
        s = $urandom_range(SLOTS - 1);
        while (m[s])
            s = $urandom_range(SLOTS - 1);
        queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, s, b));
    endtask

    // Sender: hold the word until it is taken, then advance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (!item_ch.valid || item_ch.ready) begin
            if (item_backlog.size() != 0 && !take_break()) begin
                item_ch.valid <= 1'b1;
                item_ch.data  <= item_backlog.pop_front();
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_wanted && !hold_done) begin
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            res_ch.ready <= !take_break();
        end
    end

    // Monitor: check the result word first, then predict from the input word.
    always @(posedge i_clk) begin
        mfs_pkg::t_result want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_runs.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result word %h", res_ch.data));
                end else begin
                    want = expected_runs.pop_front();
                    check_field("idle", res_ch.data.idle, want.idle);
                    check_field("run_slot", res_ch.data.run_slot, want.run_slot);
                    check_field("run_level", res_ch.data.run_level, want.run_level);
                    check_field("finished", res_ch.data.finished, want.finished);
                    check_field("turnaround", res_ch.data.turnaround, want.turnaround);
                    check_field("waiting", res_ch.data.waiting, want.waiting);
                end
                runs_checked++;
            end
            if (item_ch.valid && item_ch.ready) begin
                words_in <= words_in + 1;
                advance_scheduler(item_ch.data);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d results pending",
                     cycle_count, expected_runs.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned      useful;
        int unsigned      tick_pct;
        int               roll;
        int               s;
        logic [SLOTS-1:0] m;

        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        res_ch.ready  = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle ticks, zero burst, full-quantum completion, duplicate,
        // demotion through every level and requeue at the last level.
        queue_word(make_word(mfs_pkg::FUNC_TICK, 0, 0));
        queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, 0, 0));
        queue_word(make_word(mfs_pkg::FUNC_TICK, 7, 255));
        queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, 7, 1));
        queue_word(make_word(mfs_pkg::FUNC_TICK, 0, 0));
        queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, 0, 10));
        queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, 0, 3));
        queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, 5, 2));
        queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, 2, 4));
        repeat (12) queue_word(make_word(mfs_pkg::FUNC_TICK, 3, 85));
        queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, 1, 255));
        queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, 6, 170));
        queue_word(make_word(mfs_pkg::FUNC_TICK, 0, 0));
        queue_word(make_word(mfs_pkg::FUNC_TICK, 0, 0));

        // Random part; load changes every hundred words.
        useful   = 0;
        tick_pct = 60;
        while (useful < RANDOM_WORDS) begin
            if (useful % 100 == 0) begin
                roll = $urandom_range(2);
                tick_pct = (roll == 0) ? 50 : (roll == 1) ? 75 : 95;
            end
            if (useful >= 200)
                hold_wanted = 1'b1;
            roll = $urandom_range(99);
            m = busy_mask();
            if (roll < tick_pct) begin
                queue_tick();
            end else if (roll < tick_pct + (100 - tick_pct) * 8 / 10 && m != '1) begin
                queue_fresh_arrival(draw_burst());
            end else if ($urandom_range(1) == 0 && m != '0) begin
                // duplicate arrival for a busy slot: drop
                s = $urandom_range(SLOTS - 1);
                while (!m[s])
                    s = $urandom_range(SLOTS - 1);
                queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, s, $urandom_range(255, 1)));
            end else begin
                queue_word(make_word(mfs_pkg::FUNC_ARRIVAL, $urandom_range(SLOTS - 1), 0));
            end
            useful++;
        end

        while (item_backlog.size() != 0 || item_ch.valid)
            @(posedge i_clk);
        while (expected_runs.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_runs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== multilevel_feedback_scheduler.f =====
hdl/mfs_pkg.sv
hdl/mfs_if.sv
hdl/mfs_core.sv
hdl/mfs_out_buf.sv
hdl/multilevel_feedback_scheduler.sv
bench/tb_multilevel_feedback_scheduler.sv
